// ===== rtl/core/saw_pkg.sv =====
// Shared types and constants for the stop-and-wait ARQ endpoint.
// No dependencies; every other file of the block but saw_chan_if imports this package.
`default_nettype none

package saw_pkg;

  // Frame size limits used by the header checks.
  localparam int HEADER_BYTES = 12;
  localparam int MAX_PAYLOAD  = 1024;

  // Default depth of the queue between the front and the back.
  localparam int QUEUE_DEPTH_DEF = 2;

  // Configuration port address width: six 32-bit registers at 4*i.
  localparam int CFG_ADDR_W = 5;

  typedef enum logic [2:0] {
    REG_LOCAL_SESSION = 3'd0,
    REG_RETRY_TICKS   = 3'd1,
    REG_RETRY_LIMIT   = 3'd2,
    REG_MAGIC_WORD    = 3'd3,
    REG_DATA_TYPE     = 3'd4,
    REG_ACK_TYPE      = 3'd5
  } reg_idx_t;

  typedef enum logic [3:0] {
    EV_NONE      = 4'd0,
    EV_FIRST     = 4'd1,
    EV_RESEND    = 4'd2,
    EV_GAVEUP    = 4'd3,
    EV_ACKED     = 4'd4,
    EV_DELIVERED = 4'd5,
    EV_DUP       = 4'd6,
    EV_GAP       = 4'd7,
    EV_MALFORMED = 4'd8,
    EV_FULL      = 4'd9
  } ev_t;

  // Classification made by the front.
  typedef enum logic [1:0] {
    KIND_TICK = 2'd0,
    KIND_DATA = 2'd1,
    KIND_ACK  = 2'd2,
    KIND_BAD  = 2'd3
  } kind_t;

  typedef struct packed {
    logic [31:0] local_session;
    logic [15:0] retry_ticks;
    logic [7:0]  retry_limit;
    logic [15:0] magic_word;
    logic [7:0]  data_type_code;
    logic [7:0]  ack_type_code;
  } cfg_t;

  typedef struct packed {
    logic        mode;
    logic [31:0] now;
    logic        tx_pending;
    logic        rx_room;
    logic [10:0] frame_len;
    logic [15:0] frame_magic;
    logic [7:0]  frame_type;
    logic [31:0] frame_session;
    logic [31:0] frame_seq;
  } in_item_t;

  typedef struct packed {
    logic        send_data;
    logic [31:0] data_seq;
    logic        send_ack;
    logic [31:0] ack_session;
    logic [31:0] ack_seq;
    logic        deliver;
    logic        release_tx;
    ev_t         event_res;
  } out_item_t;

  // Classified item handed from the front to the back.
  typedef struct packed {
    kind_t       kind;
    logic        tx_pending;
    logic        rx_room;
    logic [31:0] now;
    logic [31:0] now_plus;    // now + retry_ticks, the next resend deadline
    logic [31:0] session;
    logic [31:0] seq;
    logic [31:0] seq_m1;      // seq - 1
    logic        sess_local;  // session equals local_session
  } item_t;

endpackage

`default_nettype wire

// ===== rtl/core/saw_chan_if.sv =====
// Valid/ready channel interface carrying one payload type per instance.
// Depends on nothing; the payload types come from saw_pkg at instantiation.
`default_nettype none

interface saw_chan_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

`default_nettype wire

// ===== rtl/core/stop_and_wait_arq_endpoint.sv =====
// Top level of the stop-and-wait ARQ endpoint: configuration registers and
// the front, queue and back. Depends on saw_pkg, saw_chan_if and the saw_ modules.
//
// Usage. The input channel in_ch carries either a service tick (mode 0,
// with the current time in now) or the parsed header of a received frame
// (mode 1). Every input transfer yields exactly one result transfer on
// out_ch, in order: send or resend the head data frame, give it up, retire
// it on a matching acknowledgment, or deliver, acknowledge again, ignore or
// reject a received data frame, as reported in event_res.
// Throughput is one item per clock cycle while out_ch.ready stays high. An
// accepted item is classified into the front register, then enters the queue,
// and its result is registered in the result register once it reaches the
// head of the queue.
// When the receiver holds out_ch.ready low, the result register keeps its
// transfer and the back stops; the queue and the front register keep
// accepting, so up to QueueDepth + 1 further items are taken before in_ch
// ready drops.
// Reset (rst_n low at a rising edge) restores every configuration register and all
// protocol state to its reset value at once; there is no clearing pass. The user
// must write configuration over the APB port while the block is idle; the block does not enforce it.
`default_nettype none

module stop_and_wait_arq_endpoint
  import saw_pkg::*;
#(
  parameter int QueueDepth = QUEUE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  saw_chan_if.sink              in_ch,
  saw_chan_if.source            out_ch,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  cfg_t     cfg_r, cfg_nxt;
  reg_idx_t reg_idx;
  logic     cfg_write;

  logic     wr_valid, wr_ready, rd_valid, rd_ready;
  item_t    wr_item, rd_item;

  // Configuration port: registers sit at 4*i, writes complete in the
  // access phase and the port never inserts wait states.
  assign pready    = 1'b1;
  assign reg_idx   = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_write) begin
      unique case (reg_idx)
        REG_LOCAL_SESSION: cfg_nxt.local_session  = pwdata;
        REG_RETRY_TICKS:   cfg_nxt.retry_ticks    = pwdata[15:0];
        REG_RETRY_LIMIT:   cfg_nxt.retry_limit    = pwdata[7:0];
        REG_MAGIC_WORD:    cfg_nxt.magic_word     = pwdata[15:0];
        REG_DATA_TYPE:     cfg_nxt.data_type_code = pwdata[7:0];
        REG_ACK_TYPE:      cfg_nxt.ack_type_code  = pwdata[7:0];
        default:           cfg_nxt = cfg_r;  // addresses past the register list
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_LOCAL_SESSION: prdata = cfg_r.local_session;
      REG_RETRY_TICKS:   prdata = {16'd0, cfg_r.retry_ticks};
      REG_RETRY_LIMIT:   prdata = {24'd0, cfg_r.retry_limit};
      REG_MAGIC_WORD:    prdata = {16'd0, cfg_r.magic_word};
      REG_DATA_TYPE:     prdata = {24'd0, cfg_r.data_type_code};
      REG_ACK_TYPE:      prdata = {24'd0, cfg_r.ack_type_code};
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.local_session  <= 32'd1;
      cfg_r.retry_ticks    <= 16'd100;
      cfg_r.retry_limit    <= 8'd5;
      cfg_r.magic_word     <= 16'd0;
      cfg_r.data_type_code <= 8'd0;
      cfg_r.ack_type_code  <= 8'd1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // The front checks headers against the configuration and precomputes the
  // resend deadline and the predecessor sequence number.
  saw_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_ch    (in_ch),
    .wr_valid (wr_valid),
    .wr_ready (wr_ready),
    .wr_item  (wr_item)
  );

  // The queue lets the front keep taking transfers while the back stalls.
  saw_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (wr_valid),
    .wr_ready (wr_ready),
    .wr_item  (wr_item),
    .rd_valid (rd_valid),
    .rd_ready (rd_ready),
    .rd_item  (rd_item)
  );

  // The back owns the sender and receiver state and the result register.
  saw_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .rd_valid (rd_valid),
    .rd_ready (rd_ready),
    .rd_item  (rd_item),
    .out_ch   (out_ch)
  );

endmodule

`default_nettype wire

// ===== rtl/core/saw_front.sv =====
// Front part: accepts input transfers, checks and classifies frame headers.
// Depends on saw_pkg and saw_chan_if.
`default_nettype none

module saw_front
  import saw_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  saw_chan_if.sink    in_ch,
  output logic        wr_valid,
  input  logic        wr_ready,
  output item_t       wr_item
);

  localparam int LenLimit = HEADER_BYTES + MAX_PAYLOAD;

  logic  front_valid_r, front_valid_nxt;
  item_t front_item_r, front_item_nxt;
  logic  accept;
  logic  len_short, len_long, magic_bad;
  kind_t kind;

  assign in_ch.ready = !front_valid_r || wr_ready;
  assign accept      = in_ch.valid && in_ch.ready;

  assign len_short = in_ch.payload.frame_len < 11'(HEADER_BYTES);
  assign len_long  = {1'b0, in_ch.payload.frame_len} > 12'(LenLimit);
  assign magic_bad = in_ch.payload.frame_magic != cfg.magic_word;

  // A data type match wins over an ack type match when the codes are equal.
  always_comb begin
    priority if (!in_ch.payload.mode) begin
      kind = KIND_TICK;
    end else if (len_short || magic_bad) begin
      kind = KIND_BAD;
    end else if (in_ch.payload.frame_type == cfg.data_type_code) begin
      kind = len_long ? KIND_BAD : KIND_DATA;
    end else if (in_ch.payload.frame_type == cfg.ack_type_code) begin
      kind = KIND_ACK;
    end else begin
      kind = KIND_BAD;
    end
  end

  always_comb begin
    front_item_nxt.kind       = kind;
    front_item_nxt.tx_pending = in_ch.payload.tx_pending;
    front_item_nxt.rx_room    = in_ch.payload.rx_room;
    front_item_nxt.now        = in_ch.payload.now;
    front_item_nxt.now_plus   = in_ch.payload.now + {16'd0, cfg.retry_ticks};
    front_item_nxt.session    = in_ch.payload.frame_session;
    front_item_nxt.seq        = in_ch.payload.frame_seq;
    front_item_nxt.seq_m1     = in_ch.payload.frame_seq - 32'd1;
    front_item_nxt.sess_local = in_ch.payload.frame_session == cfg.local_session;
  end

  assign front_valid_nxt = accept || (front_valid_r && !wr_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_valid_r <= 1'b0;
    end else begin
      front_valid_r <= front_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      front_item_r <= front_item_nxt;
    end
  end

  assign wr_valid = front_valid_r;
  assign wr_item  = front_item_r;

endmodule

`default_nettype wire

// ===== rtl/core/saw_queue.sv =====
// Short first-in first-out queue of classified items between front and back.
// Depends on saw_pkg.
`default_nettype none

module saw_queue
  import saw_pkg::*;
#(
  parameter int Depth = QUEUE_DEPTH_DEF
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  wr_valid,
  output logic  wr_ready,
  input  item_t wr_item,
  output logic  rd_valid,
  input  logic  rd_ready,
  output item_t rd_item
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  item_t            q_r [Depth];
  logic [PtrW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]  count_r, count_nxt;
  logic             push, pop;

  assign wr_ready = count_r != CntW'(Depth);
  assign rd_valid = count_r != '0;
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;
  assign rd_item  = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(Depth - 1)) ? '0 : wr_ptr_r + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(Depth - 1)) ? '0 : rd_ptr_r + PtrW'(1);
    end
    unique case ({push, pop})
      2'b10:   count_nxt = count_r + CntW'(1);
      2'b01:   count_nxt = count_r - CntW'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= wr_item;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/saw_back.sv =====
// Back part: holds the protocol state, carries out classified items and
// registers one result per item. Depends on saw_pkg and saw_chan_if.
`default_nettype none

module saw_back
  import saw_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  logic        rd_valid,
  output logic        rd_ready,
  input  item_t       rd_item,
  saw_chan_if.source  out_ch
);

  logic [31:0] seq_alloc_r,    seq_alloc_nxt;
  logic        in_flight_r,    in_flight_nxt;
  logic [31:0] sent_seq_r,     sent_seq_nxt;
  logic [8:0]  retry_r,        retry_nxt;
  logic [31:0] deadline_r,     deadline_nxt;
  logic        peer_valid_r,   peer_valid_nxt;
  logic [31:0] peer_session_r, peer_session_nxt;
  logic [31:0] peer_last_r,    peer_last_nxt;
  logic        out_valid_r,    out_valid_nxt;
  out_item_t   out_r,          out_nxt;

  logic        load;
  logic [31:0] time_diff, seq_diff;
  logic        due, behind, is_new, is_next, give_up;
  logic [8:0]  retry_inc;

  assign rd_ready = !out_valid_r || out_ch.ready;
  assign load     = rd_valid && rd_ready;

  // Wrapping order tests use the sign of the 32-bit difference.
  assign time_diff = rd_item.now - deadline_r;
  assign due       = !time_diff[31];
  assign seq_diff  = rd_item.seq - peer_last_r;
  assign behind    = seq_diff[31] || (rd_item.seq == peer_last_r);
  assign is_new    = !peer_valid_r || (rd_item.session != peer_session_r);
  assign is_next   = rd_item.seq_m1 == peer_last_r;
  assign retry_inc = retry_r + 9'd1;
  assign give_up   = retry_inc > {1'b0, cfg.retry_limit};

  always_comb begin
    seq_alloc_nxt    = seq_alloc_r;
    in_flight_nxt    = in_flight_r;
    sent_seq_nxt     = sent_seq_r;
    retry_nxt        = retry_r;
    deadline_nxt     = deadline_r;
    peer_valid_nxt   = peer_valid_r;
    peer_session_nxt = peer_session_r;
    peer_last_nxt    = peer_last_r;
    out_nxt          = '0;
    out_nxt.event_res = EV_NONE;

    unique case (rd_item.kind)
      KIND_TICK: begin
        if (rd_item.tx_pending) begin
          if (!in_flight_r) begin
            sent_seq_nxt      = seq_alloc_r;
            seq_alloc_nxt     = seq_alloc_r + 32'd1;
            in_flight_nxt     = 1'b1;
            retry_nxt         = '0;
            deadline_nxt      = rd_item.now_plus;
            out_nxt.send_data = 1'b1;
            out_nxt.data_seq  = seq_alloc_r;
            out_nxt.event_res = EV_FIRST;
          end else if (due) begin
            if (give_up) begin
              out_nxt.release_tx = 1'b1;
              in_flight_nxt      = 1'b0;
              retry_nxt          = '0;
              out_nxt.event_res  = EV_GAVEUP;
            end else begin
              retry_nxt         = retry_inc;
              deadline_nxt      = rd_item.now_plus;
              out_nxt.send_data = 1'b1;
              out_nxt.data_seq  = sent_seq_r;
              out_nxt.event_res = EV_RESEND;
            end
          end
        end
      end
      KIND_DATA: begin
        if (is_new || is_next) begin
          // A new session is adopted even when the ring turns out to be full.
          peer_valid_nxt   = 1'b1;
          peer_session_nxt = rd_item.session;
          if (rd_item.rx_room) begin
            peer_last_nxt       = rd_item.seq;
            out_nxt.deliver     = 1'b1;
            out_nxt.send_ack    = 1'b1;
            out_nxt.ack_session = rd_item.session;
            out_nxt.ack_seq     = rd_item.seq;
            out_nxt.event_res   = EV_DELIVERED;
          end else begin
            peer_last_nxt     = rd_item.seq_m1;
            out_nxt.event_res = EV_FULL;
          end
        end else if (behind) begin
          out_nxt.send_ack    = 1'b1;
          out_nxt.ack_session = rd_item.session;
          out_nxt.ack_seq     = rd_item.seq;
          out_nxt.event_res   = EV_DUP;
        end else begin
          out_nxt.event_res = EV_GAP;
        end
      end
      KIND_ACK: begin
        if (in_flight_r && rd_item.sess_local && (rd_item.seq == sent_seq_r)) begin
          out_nxt.release_tx = 1'b1;
          in_flight_nxt      = 1'b0;
          retry_nxt          = '0;
          out_nxt.event_res  = EV_ACKED;
        end
      end
      KIND_BAD: begin
        out_nxt.event_res = EV_MALFORMED;
      end
      default: begin
        out_nxt.event_res = EV_NONE;
      end
    endcase
  end

  assign out_valid_nxt = load || (out_valid_r && !out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_alloc_r    <= 32'd1;
      in_flight_r    <= 1'b0;
      sent_seq_r     <= '0;
      retry_r        <= '0;
      deadline_r     <= '0;
      peer_valid_r   <= 1'b0;
      peer_session_r <= '0;
      peer_last_r    <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (load) begin
        seq_alloc_r    <= seq_alloc_nxt;
        in_flight_r    <= in_flight_nxt;
        sent_seq_r     <= sent_seq_nxt;
        retry_r        <= retry_nxt;
        deadline_r     <= deadline_nxt;
        peer_valid_r   <= peer_valid_nxt;
        peer_session_r <= peer_session_nxt;
        peer_last_r    <= peer_last_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_r <= out_nxt;
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.payload = out_r;

`ifndef ASSERT_OFF
  a_flight_starts_with_first: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_flight_r) |-> out_valid_r && (out_r.event_res == EV_FIRST))
    else $error("frame went in flight without a first send result");

  a_release_ends_flight: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.release_tx |->
      !in_flight_r && (out_r.event_res == EV_GAVEUP || out_r.event_res == EV_ACKED))
    else $error("release result does not match the flight state");

  a_send_matches_flight: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.send_data |-> in_flight_r && (out_r.data_seq == sent_seq_r))
    else $error("sent sequence differs from the frame in flight");
`endif

endmodule

`default_nettype wire
